// ----- hw/rtl/fdmb_pkg.sv -----
// Shared types and constants for the frame difference motion bounds block.
package fdmb_pkg;

    localparam int COORD_BITS     = 12;
    localparam int COUNT_BITS     = 25;
    localparam int GRAY_BITS      = 8;
    localparam int PCT_BITS       = 7;
    localparam int QUO_BITS       = PCT_BITS + 1;
    localparam int REM_BITS       = COUNT_BITS + PCT_BITS;
    localparam int STEP_BITS      = $clog2(QUO_BITS);
    localparam int CFG_DATA_BITS  = COUNT_BITS;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [PCT_BITS-1:0] PCT_FULL = PCT_BITS'(100);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DIFF_THR,
        REG_PCT_THR,
        REG_DIVISOR,
        REG_BOX_MIN_X,
        REG_BOX_MAX_X,
        REG_BOX_MIN_Y,
        REG_BOX_MAX_Y,
        REG_USE_MASK
    } cfg_index_t;

    typedef struct packed {
        logic [GRAY_BITS-1:0]  diff_threshold;
        logic [PCT_BITS-1:0]   percent_threshold;
        logic [COUNT_BITS-1:0] divisor_count;
        logic [COORD_BITS-1:0] box_min_x;
        logic [COORD_BITS-1:0] box_max_x;
        logic [COORD_BITS-1:0] box_min_y;
        logic [COORD_BITS-1:0] box_max_y;
        logic                  use_mask;
    } cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pix_x;
        logic [COORD_BITS-1:0] pix_y;
        logic [GRAY_BITS-1:0]  prev_gray;
        logic [GRAY_BITS-1:0]  curr_gray;
        logic                  mask_bit;
        logic                  frame_end;
    } pix_word_t;

    typedef struct packed {
        logic [PCT_BITS-1:0]   change_percent;
        logic                  motion_flag;
        logic [COORD_BITS-1:0] left_x;
        logic [COORD_BITS-1:0] right_x;
        logic [COORD_BITS-1:0] top_y;
        logic [COORD_BITS-1:0] bottom_y;
    } res_word_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_SCALE,
        ST_DIVIDE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic take_pixel;
        logic load_scale;
        logic div_step;
        logic load_result;
    } dp_cmd_t;

    typedef struct packed {
        logic frame_end;
    } dp_stat_t;

endpackage

// ----- hw/rtl/frame_diff_motion_bounds.sv -----
// Top level of the frame difference motion detector with changed-pixel bounds.
//
// Usage:
//   pix channel (pix_valid/pix_ready/pix) carries one word per pixel: column, row,
//   previous and current gray value, mask bit and end-of-frame mark. Pixels are
//   taken one per cycle while the block is accumulating a frame.
//   res channel (res_valid/res_ready/res) carries one word per frame: percent of
//   changed pixels, motion flag and the bounding box of changed pixels.
//   The cfg port (cfg_we, cfg_index, cfg_data) writes one register per cycle;
//   write only while no frame is in flight.
// Timing:
//   After the end-of-frame pixel the percent is computed by a restoring divider
//   that yields one quotient bit per cycle: a scaling step, eight divide steps
//   and a load step; pix_ready stays low until the result has been loaded.
//   The result register frees the input: the next frame streams in while a
//   result waits; only loading the next result waits for that one to be taken.
// Reset:
//   Configuration registers return to their defaults, no result is pending and
//   the next pixel opens a new frame.
module frame_diff_motion_bounds
    import fdmb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pix_valid,
    output logic                      pix_ready,
    input  pix_word_t                 pix,
    output logic                      res_valid,
    input  logic                      res_ready,
    output res_word_t                 res,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    fdmb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fdmb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fdmb_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .pix   (pix),
        .cmd   (cmd),
        .stat  (stat),
        .res   (res)
    );

    a_percent_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.change_percent <= PCT_FULL))
        else $error("percent above full scale");

endmodule

// ----- hw/rtl/fdmb_regs.sv -----
// Configuration register file of the motion bounds block.
module fdmb_regs
    import fdmb_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_DIFF_THR:  cfg_next.diff_threshold    = cfg_data[GRAY_BITS-1:0];
                REG_PCT_THR:   cfg_next.percent_threshold = cfg_data[PCT_BITS-1:0];
                REG_DIVISOR:   cfg_next.divisor_count     = cfg_data[COUNT_BITS-1:0];
                REG_BOX_MIN_X: cfg_next.box_min_x         = cfg_data[COORD_BITS-1:0];
                REG_BOX_MAX_X: cfg_next.box_max_x         = cfg_data[COORD_BITS-1:0];
                REG_BOX_MIN_Y: cfg_next.box_min_y         = cfg_data[COORD_BITS-1:0];
                REG_BOX_MAX_Y: cfg_next.box_max_y         = cfg_data[COORD_BITS-1:0];
                REG_USE_MASK:  cfg_next.use_mask          = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{
                diff_threshold:    '0,
                percent_threshold: PCT_FULL,
                divisor_count:     COUNT_BITS'(1),
                box_min_x:         '0,
                box_max_x:         '0,
                box_min_y:         '0,
                box_max_y:         '0,
                use_mask:          1'b0
            };
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/fdmb_dp.sv -----
// Datapath: pixel test, count and bounds tracking, percent divider, result register.
module fdmb_dp
    import fdmb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  pix_word_t pix,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output res_word_t res
);

    logic                  rearm_reg, rearm_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COORD_BITS-1:0] min_x_reg, min_x_next;
    logic [COORD_BITS-1:0] max_x_reg, max_x_next;
    logic [COORD_BITS-1:0] min_y_reg, min_y_next;
    logic [COORD_BITS-1:0] max_y_reg, max_y_next;
    logic [REM_BITS-1:0]   rem_reg, rem_next;
    logic [REM_BITS-1:0]   dsr_reg, dsr_next;
    logic [QUO_BITS-1:0]   quo_reg, quo_next;
    res_word_t             res_reg, res_next;

    logic [COUNT_BITS-1:0] count_base;
    logic [COORD_BITS-1:0] min_x_base, max_x_base, min_y_base, max_y_base;
    logic [GRAY_BITS-1:0]  abs_diff;
    logic                  in_box;
    logic                  changed;
    logic [REM_BITS-1:0]   count_wide;
    logic [REM_BITS-1:0]   scaled;
    logic [COUNT_BITS-1:0] divisor_eff;
    logic                  rem_ge;
    logic [PCT_BITS-1:0]   pct;

    always_comb
    begin
        count_base = rearm_reg ? '0 : count_reg;
        min_x_base = rearm_reg ? cfg.box_max_x : min_x_reg;
        max_x_base = rearm_reg ? cfg.box_min_x : max_x_reg;
        min_y_base = rearm_reg ? cfg.box_max_y : min_y_reg;
        max_y_base = rearm_reg ? cfg.box_min_y : max_y_reg;

        abs_diff = (pix.curr_gray >= pix.prev_gray) ? (pix.curr_gray - pix.prev_gray)
                                                    : (pix.prev_gray - pix.curr_gray);
        in_box   = (pix.pix_x >= cfg.box_min_x) && (pix.pix_x <= cfg.box_max_x) &&
                   (pix.pix_y >= cfg.box_min_y) && (pix.pix_y <= cfg.box_max_y);
        changed  = in_box && (!cfg.use_mask || pix.mask_bit) &&
                   (abs_diff >= cfg.diff_threshold);

        count_wide  = REM_BITS'(count_reg);
        scaled      = (count_wide << 6) + (count_wide << 5) + (count_wide << 2);
        divisor_eff = (cfg.divisor_count == '0) ? COUNT_BITS'(1) : cfg.divisor_count;
        rem_ge      = (rem_reg >= dsr_reg);
        pct         = (quo_reg > QUO_BITS'(PCT_FULL)) ? PCT_FULL : quo_reg[PCT_BITS-1:0];

        rearm_next = rearm_reg;
        count_next = count_reg;
        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        quo_next   = quo_reg;
        res_next   = res_reg;

        if (cmd.take_pixel)
        begin
            rearm_next = pix.frame_end;
            count_next = (changed && (count_base != '1)) ? count_base + COUNT_BITS'(1)
                                                          : count_base;
            min_x_next = (changed && (pix.pix_x < min_x_base)) ? pix.pix_x : min_x_base;
            max_x_next = (changed && (pix.pix_x > max_x_base)) ? pix.pix_x : max_x_base;
            min_y_next = (changed && (pix.pix_y < min_y_base)) ? pix.pix_y : min_y_base;
            max_y_next = (changed && (pix.pix_y > max_y_base)) ? pix.pix_y : max_y_base;
        end

        if (cmd.load_scale)
        begin
            rem_next = scaled;
            dsr_next = REM_BITS'(divisor_eff) << (QUO_BITS - 1);
            quo_next = '0;
        end

        if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_next = rem_reg - dsr_reg;
            end
            dsr_next = dsr_reg >> 1;
            quo_next = {quo_reg[QUO_BITS-2:0], rem_ge};
        end

        if (cmd.load_result)
        begin
            res_next.change_percent = pct;
            res_next.motion_flag    = (pct >= cfg.percent_threshold);
            res_next.left_x         = min_x_reg;
            res_next.right_x        = max_x_reg;
            res_next.top_y          = min_y_reg;
            res_next.bottom_y       = max_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rearm_reg <= 1'b1;
        end
        else
        begin
            rearm_reg <= rearm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        min_x_reg <= min_x_next;
        max_x_reg <= max_x_next;
        min_y_reg <= min_y_next;
        max_y_reg <= max_y_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        quo_reg   <= quo_next;
        res_reg   <= res_next;
    end

    assign stat.frame_end = pix.frame_end;
    assign res            = res_reg;

endmodule

// ----- hw/rtl/fdmb_ctrl.sv -----
// Controller: pixel intake, divide sequencing and result handshake.
module fdmb_ctrl
    import fdmb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pix_valid,
    output logic     pix_ready,
    output logic     res_valid,
    input  logic     res_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t          state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 res_valid_reg, res_valid_next;
    logic                 slot_free;

    assign slot_free = !res_valid_reg || res_ready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                if (pix_valid && stat.frame_end)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_DIVIDE;
                step_next  = STEP_BITS'(QUO_BITS - 1);
            end
            ST_DIVIDE:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next = step_reg - STEP_BITS'(1);
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        pix_ready = 1'b0;
        case (state_reg)
            ST_ACCUM:
            begin
                pix_ready      = 1'b1;
                cmd.take_pixel = pix_valid;
            end
            ST_SCALE:
            begin
                cmd.load_scale = 1'b1;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.load_result = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign res_valid_next = cmd.load_result || (res_valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

    a_frame_end_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready && stat.frame_end) |=> (state_reg == ST_SCALE))
        else $error("frame end did not start the divide");

    a_scale_arms_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE) |=>
            (state_reg == ST_DIVIDE && step_reg == STEP_BITS'(QUO_BITS - 1)))
        else $error("divide not armed with full step count");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!res_valid || res_ready))
        else $error("result overwritten before it was taken");

    a_load_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> res_valid)
        else $error("loaded result not presented");

endmodule
